[design/hlpim_pkg.sv]
// Shared types, constants and trig table builder for the Hough line-pair
// intersection mean block. No dependencies.
`timescale 1ns / 1ps
package hlpim_pkg;

    localparam int MAX_LINES_DEF   = 64;
    localparam int ANGLE_STEPS_DEF = 180;
    localparam int TRIG_FRAC_DEF   = 15;

    localparam int RHO_W   = 11;
    localparam int ANGLE_W = 8;
    localparam int X_W     = 24;
    localparam int PC_OUT_W = 11;
    localparam int TRIG_W_MAX = 26;
    localparam int ANGLE_CODES = 256;
    localparam int FIFO_DEPTH = 4;

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam int X_MAX = 8388607;
    localparam int X_MIN = -8388608;

    typedef enum logic {CMD_STORE, CMD_DROP} cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic                      last;
        logic signed [RHO_W-1:0]   rho;
        logic [ANGLE_W-1:0]        angle;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_TRIG, S_MUL, S_SUB, S_DIVGO, S_DIVW, S_MEAN, S_MEANW, S_OUT
    } back_state_t;

    typedef logic signed [TRIG_W_MAX-1:0] trig_tab_t [ANGLE_CODES];

    // Shift-and-subtract quotient of two non-negative values, table build only
    function automatic longint udiv(longint num, longint den);
        longint qv;
        longint rv;
        int     b;
        qv = 0;
        rv = 0;
        for (b = 62; b >= 0; b--) begin
            rv = (rv <<< 1) | ((num >>> b) & 64'sd1);
            if (rv >= den) begin
                rv = rv - den;
                qv = qv | (64'sd1 <<< b);
            end
        end
        return qv;
    endfunction

    function automatic longint series_q30(longint x, bit cosine);
        longint term;
        longint sum;
        longint n;
        int     k;
        term = cosine ? (64'sd1 <<< 30) : x;
        sum  = term;
        n    = cosine ? 0 : 1;
        for (k = 1; k <= 12; k++) begin
            term = (((term * x) >>> 30) * x) >>> 30;
            term = udiv(term, (n + 1) * (n + 2));
            n    = n + 2;
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic longint to_frac(longint v_in, int Fb);
        longint v;
        longint r;
        v = (v_in < 0) ? 64'sd0 : v_in;
        r = (v + (64'sd1 <<< (29 - Fb))) >>> (30 - Fb);
        if (r > (64'sd1 <<< Fb)) begin
            r = 64'sd1 <<< Fb;
        end
        return r;
    endfunction

    // Table indexed by the raw 8-bit angle code
    function automatic trig_tab_t build_tab(int Steps, int Fb, bit cosine);
        trig_tab_t t;
        longint    idx;
        longint    i;
        longint    j;
        longint    x;
        longint    r;
        bit        flip;
        bit        cneg;
        int        a;
        for (a = 0; a < ANGLE_CODES; a++) begin
            idx = udiv(longint'(a) * Steps, 180);
            if (idx >= 2 * Steps) begin
                idx = 2 * Steps - 1;
            end
            i    = idx;
            flip = 1'b0;
            if (i >= Steps) begin
                i    = i - Steps;
                flip = 1'b1;
            end
            cneg = (2 * i > Steps);
            j    = cneg ? (Steps - i) : i;
            x    = udiv(j * PI_Q30, Steps);
            r    = to_frac(series_q30(x, cosine), Fb);
            if (cosine && cneg) begin
                r = -r;
            end
            if (flip) begin
                r = -r;
            end
            t[a] = TRIG_W_MAX'(r);
        end
        return t;
    endfunction

endpackage

[design/hlpim_front.sv]
// Input side: accepts line words and tags each as kept or dropped.
// Depends on hlpim_pkg.
`timescale 1ns / 1ps
module hlpim_front import hlpim_pkg::*; #(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [10:0] line_rho, [18:11] line_angle
    input  logic                 s_tlast,   // last_line
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);
    localparam int CW = $clog2(MAX_LINES + 1);

    logic [CW-1:0] cnt_reg, cnt_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_cmd.kind  = (cnt_reg < CW'(MAX_LINES)) ? CMD_STORE : CMD_DROP;
        q_cmd.last  = s_tlast;
        q_cmd.rho   = $signed(s_tdata[RHO_W-1:0]);
        q_cmd.angle = s_tdata[RHO_W+ANGLE_W-1:RHO_W];
        cnt_next    = cnt_reg;
        if (q_push) begin
            if (s_tlast) begin
                cnt_next = '0;
            end else if (q_cmd.kind == CMD_STORE) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end
endmodule

[design/hlpim_fifo.sv]
// Short command queue between the front and back parts.
// Depends on hlpim_pkg.
`timescale 1ns / 1ps
module hlpim_fifo import hlpim_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);
    localparam int PW = $clog2(FIFO_DEPTH);

    cmd_t          mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   fill_reg;

    assign full  = (fill_reg == (PW+1)'(FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end
endmodule

[design/hlpim_div.sv]
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on hlpim_pkg.
`timescale 1ns / 1ps
module hlpim_div import hlpim_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 36
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic signed [DW-1:0] divisor,
    output logic                 done,
    output logic signed [NW-1:0] quotient
);
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] rem_reg;
    logic          neg_reg;
    logic          run_reg;
    logic          done_reg;
    logic [KW-1:0] cnt_reg;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb begin
        trial = {rem_reg, dvd_reg[NW-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
            dvs_reg <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[NW-1] ^ divisor[DW-1];
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[NW-2:0], qbit};
            rem_reg <= qbit ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == KW'(NW - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[design/hlpim_back.sv]
// Back part: line store, pair sweep with trig lookup, intersection and mean,
// result register. Depends on hlpim_pkg and hlpim_div.
`timescale 1ns / 1ps
module hlpim_back import hlpim_pkg::*; #(
    parameter int MAX_LINES      = MAX_LINES_DEF,
    parameter int ANGLE_STEPS    = ANGLE_STEPS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [23:0] center_x, [34:24] pair_count
    output logic [1:0]  m_tuser    // [0] no_pairs, [1] lines_dropped
);
    localparam int F    = TRIG_FRAC_BITS;
    localparam int TW   = F + 2;
    localparam int AW   = $clog2(MAX_LINES);
    localparam int CW   = AW + 1;
    localparam int PW   = 2 * TW;
    localparam int DETW = PW + 1;
    localparam int RPW  = RHO_W + TW;
    localparam int NUMW = RPW + 1;
    localparam int PCW  = $clog2(MAX_LINES * (MAX_LINES - 1) / 2 + 1);
    localparam int SUMW = X_W + PCW;
    localparam int NW1  = NUMW + F + 1;
    localparam int NW   = (NW1 > SUMW + 1) ? NW1 : SUMW + 1;
    localparam int DW   = (DETW > PCW + 1) ? DETW : PCW + 1;

    localparam trig_tab_t SIN_TAB = build_tab(ANGLE_STEPS, F, 1'b0);
    localparam trig_tab_t COS_TAB = build_tab(ANGLE_STEPS, F, 1'b1);
    localparam logic signed [NW-1:0] QMAX = NW'(X_MAX);
    localparam logic signed [NW-1:0] QMIN = NW'(X_MIN);

    logic signed [RHO_W-1:0]   rho_mem [MAX_LINES];
    logic [ANGLE_W-1:0]        ang_mem [MAX_LINES];

    back_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic [PCW-1:0] pairs_reg, pairs_next;

    logic signed [RHO_W-1:0] rho1_rd_reg, rho2_rd_reg;
    logic [ANGLE_W-1:0]      ang1_rd_reg, ang2_rd_reg;
    logic signed [TW-1:0]    s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [RHO_W-1:0] rho1_reg, rho2_reg;
    logic signed [PW-1:0]    pa_reg, pb_reg;
    logic signed [RPW-1:0]   pc_reg, pd_reg;
    logic signed [DETW-1:0]  det_reg;
    logic signed [NUMW-1:0]  num_reg;

    logic                  div_start, div_done;
    logic signed [NW-1:0]  div_dvd, q, qsat;
    logic signed [DW-1:0]  div_dvs;

    logic                  out_valid_reg;
    logic signed [X_W-1:0] out_x_reg;
    logic [PC_OUT_W-1:0]   out_pc_reg;
    logic                  out_np_reg, out_ovf_reg;
    logic                  out_load;
    logic signed [X_W-1:0] out_x_next;
    logic                  mem_we;

    hlpim_div #(.NW(NW), .DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_pc_reg, out_x_reg};
    assign m_tuser  = {out_ovf_reg, out_np_reg};

    always_comb begin
        if (q > QMAX) begin
            qsat = QMAX;
        end else if (q < QMIN) begin
            qsat = QMIN;
        end else begin
            qsat = q;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        sum_next   = sum_reg;
        pairs_next = pairs_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        div_dvd    = NW'(num_reg) <<< F;
        div_dvs    = DW'(det_reg);
        out_load   = 1'b0;
        out_x_next = '0;
        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_head.kind == CMD_STORE) begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (q_head.last) begin
                        i_next     = '0;
                        j_next     = CW'(1);
                        sum_next   = '0;
                        pairs_next = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = (j_reg < cnt_reg) ? S_TRIG : S_MEAN;
            end
            S_TRIG:  state_next = S_MUL;
            S_MUL:   state_next = S_SUB;
            S_SUB:   state_next = S_DIVGO;
            S_DIVGO: begin
                if (det_reg == '0) begin
                    state_next = S_RD;
                    if (j_reg + 1'b1 == cnt_reg) begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + CW'(2);
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    sum_next   = sum_reg + SUMW'(qsat);
                    pairs_next = pairs_reg + 1'b1;
                    state_next = S_RD;
                    if (j_reg + 1'b1 == cnt_reg) begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + CW'(2);
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            S_MEAN: begin
                if (pairs_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    div_dvd    = NW'(sum_reg);
                    div_dvs    = $signed(DW'(pairs_reg));
                    div_start  = 1'b1;
                    state_next = S_MEANW;
                end
            end
            S_MEANW: begin
                if (div_done) begin
                    sum_next   = SUMW'(q);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the result slot is free
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    out_x_next = (pairs_reg == '0) ? '0 : sum_reg[X_W-1:0];
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rho_mem[cnt_reg[AW-1:0]] <= q_head.rho;
            ang_mem[cnt_reg[AW-1:0]] <= q_head.angle;
        end
        rho1_rd_reg <= rho_mem[i_reg[AW-1:0]];
        ang1_rd_reg <= ang_mem[i_reg[AW-1:0]];
        rho2_rd_reg <= rho_mem[j_reg[AW-1:0]];
        ang2_rd_reg <= ang_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        s1_reg   <= TW'(SIN_TAB[ang1_rd_reg]);
        c1_reg   <= TW'(COS_TAB[ang1_rd_reg]);
        s2_reg   <= TW'(SIN_TAB[ang2_rd_reg]);
        c2_reg   <= TW'(COS_TAB[ang2_rd_reg]);
        rho1_reg <= rho1_rd_reg;
        rho2_reg <= rho2_rd_reg;
        pa_reg   <= c1_reg * s2_reg;
        pb_reg   <= c2_reg * s1_reg;
        pc_reg   <= RPW'(rho1_reg) * RPW'(s2_reg);
        pd_reg   <= RPW'(rho2_reg) * RPW'(s1_reg);
        det_reg  <= DETW'(pa_reg) - DETW'(pb_reg);
        num_reg  <= NUMW'(pc_reg) - NUMW'(pd_reg);
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg   <= out_x_next;
            out_pc_reg  <= PC_OUT_W'(pairs_reg);
            out_np_reg  <= (pairs_reg == '0);
            out_ovf_reg <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            sum_reg       <= '0;
            pairs_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            sum_reg   <= sum_next;
            pairs_reg <= pairs_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

[design/hough_line_pair_intersection_mean.sv]
// Hough line-pair intersection mean. Lines (rho, angle) are taken one word a
// cycle while the queue is not full into a four-word queue and written into
// a line store; the word with tlast starts a sweep over every pair i < j of
// stored lines. Each pair goes through read, lookup, multiply and subtract
// plus, when not parallel, one pass of the shared one-bit-a-cycle divider;
// then, if any pair gave a result, one more divider pass forms the mean.
// Trig values default to 15 fraction bits. Words keep queueing while a sweep
// runs, until the queue fills.
`timescale 1ns / 1ps
module hough_line_pair_intersection_mean import hlpim_pkg::*; #(
    parameter int MAX_LINES      = MAX_LINES_DEF,
    parameter int ANGLE_STEPS    = ANGLE_STEPS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] line_rho, [18:11] line_angle
    input  logic        s_tlast,   // last_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [23:0] center_x, [34:24] pair_count
    output logic [1:0]  m_tuser    // [0] no_pairs, [1] lines_dropped
);
    logic q_full, q_push, q_empty, q_pop;
    cmd_t q_cmd, q_head;

    hlpim_front #(.MAX_LINES(MAX_LINES)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    hlpim_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    hlpim_back #(
        .MAX_LINES      (MAX_LINES),
        .ANGLE_STEPS    (ANGLE_STEPS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

[sim/tb_top.sv]
// Self-checking bench for hough_line_pair_intersection_mean: streams Hough lines in
// frames and compares every mean result against an in-bench line-pair predictor.
// Depends on hlpim_pkg and the block itself.
`timescale 1ns / 1ps

typedef struct {
    logic signed [23:0] center_x;
    logic [10:0]        pair_count;
    logic               no_pairs;
    logic               lines_dropped;
} frame_mean_t;

class line_pair_board;
    longint      sin_q [256];
    longint      cos_q [256];
    longint      rho_q [$];
    int          ang_q [$];
    bit          dropped;
    frame_mean_t mean_q [$];
    int          errors;
    int          results_seen;

    function new();
        int a;
        for (a = 0; a < 256; a++) begin
            fill_trig(a);
        end
        dropped = 0;
        errors = 0;
        results_seen = 0;
    endfunction

    // Taylor series in Q30, 13 terms
    function longint taylor(longint x, bit is_cos);
        longint term;
        longint acc;
        longint n;
        int     k;
        term = is_cos ? (64'sd1 <<< 30) : x;
        acc = term;
        n = is_cos ? 0 : 1;
        for (k = 1; k <= 12; k++) begin
            term = (((term * x) >>> 30) * x) >>> 30;
            term = term / ((n + 1) * (n + 2));
            n = n + 2;
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    function longint q15(longint v);
        longint r;
        if (v < 0) v = 0;
        r = (v + (64'sd1 <<< 14)) >>> 15;
        if (r > 32768) r = 32768;
        return r;
    endfunction

    // Fold the angle into the first quadrant, then restore the signs
    function void fill_trig(int a);
        longint i;
        longint j;
        longint x;
        longint s;
        longint c;
        bit     flip;
        bit     cneg;
        i = a;
        flip = 0;
        if (i >= 180) begin
            i = i - 180;
            flip = 1;
        end
        cneg = (2 * i > 180);
        j = cneg ? 180 - i : i;
        x = j * 64'sd3373259426 / 180;
        s = q15(taylor(x, 0));
        c = q15(taylor(x, 1));
        if (cneg) c = -c;
        if (flip) begin
            s = -s;
            c = -c;
        end
        sin_q[a] = s;
        cos_q[a] = c;
    endfunction

    function void note_line(logic signed [10:0] rho, logic [7:0] angle, logic last);
        frame_mean_t e;
        longint      xsum;
        longint      pairs;
        longint      det;
        longint      num;
        longint      x;
        longint      mean;
        int          i;
        int          j;
        if (rho_q.size() < 64) begin
            rho_q.push_back(longint'(rho));
            ang_q.push_back(int'(angle));
        end else begin
            dropped = 1;
        end
        if (!last) return;
        xsum = 0;
        pairs = 0;
        for (i = 0; i < rho_q.size(); i++) begin
            for (j = i + 1; j < rho_q.size(); j++) begin
                det = cos_q[ang_q[i]] * sin_q[ang_q[j]] - cos_q[ang_q[j]] * sin_q[ang_q[i]];
                if (det == 0) continue;
                num = rho_q[i] * sin_q[ang_q[j]] - rho_q[j] * sin_q[ang_q[i]];
                x = (num * 32768) / det;
                if (x > 8388607) x = 8388607;
                if (x < -8388608) x = -8388608;
                xsum += x;
                pairs++;
            end
        end
        mean = (pairs > 0) ? xsum / pairs : 0;
        e.center_x = mean[23:0];
        e.pair_count = pairs[10:0];
        e.no_pairs = (pairs == 0);
        e.lines_dropped = dropped;
        mean_q.push_back(e);
        rho_q.delete();
        ang_q.delete();
        dropped = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [39:0] data, logic [1:0] user);
        frame_mean_t e;
        results_seen++;
        if (mean_q.size() == 0) begin
            report("result word with nothing outstanding");
            return;
        end
        e = mean_q.pop_front();
        if (data[23:0] !== e.center_x)
            report($sformatf("center_x %0d, want %0d", $signed(data[23:0]), e.center_x));
        if (data[34:24] !== e.pair_count)
            report($sformatf("pair_count %0d, want %0d", data[34:24], e.pair_count));
        if (user[0] !== e.no_pairs)
            report($sformatf("no_pairs %0b, want %0b", user[0], e.no_pairs));
        if (user[1] !== e.lines_dropped)
            report($sformatf("lines_dropped %0b, want %0b", user[1], e.lines_dropped));
    endtask
endclass

module tb_top;
    import hlpim_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    line_pair_board board = new();
    int  lines_sent = 0;
    int  frames_sent = 0;
    bit  stim_done = 0;
    bit  hold_out = 0;
    bit  no_gaps = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    hough_line_pair_intersection_mean uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    task automatic send_line(logic signed [10:0] rho, logic [7:0] angle, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'b0, angle, rho};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_line(rho, angle, last);
        lines_sent++;
        if (last) frames_sent++;
    endtask

    task automatic send_frame(int n);
        int k;
        int pick;
        logic [7:0] ang;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) ang = 8'($urandom_range(0, 3) * 45);
            else if (pick == 2) ang = 8'($urandom_range(180, 255));
            else ang = 8'($urandom_range(0, 179));
            send_line(11'($urandom), ang, k == n - 1);
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_out) begin
                gap = 3000;
                hold_out = 0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata, m_tuser);
        end
    end

    initial begin
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // extremes of rho and angle, parallel pairs, lone line
        send_line(-11'sd1024, 8'd0, 0);
        send_line(11'sd1023, 8'd90, 1);
        send_line(11'sd0, 8'd179, 0);
        send_line(11'sd1023, 8'd180, 0);
        send_line(-11'sd1024, 8'd255, 1);
        send_line(11'sd5, 8'd45, 0);
        send_line(11'sd100, 8'd45, 1);
        send_line(11'sd17, 8'd0, 0);
        send_line(-11'sd17, 8'd180, 1);
        send_line(11'sd300, 8'd33, 1);
        send_line(11'sd1023, 8'd1, 0);
        send_line(-11'sd1024, 8'd2, 0);
        send_line(11'sd1023, 8'd178, 1);
        // block fills while the result side holds off
        hold_out = 1;
        for (k = 0; k < 6; k++) send_frame($urandom_range(1, 3));
        // store overflow: one frame past capacity, then one exactly full
        send_frame(66);
        send_frame(64);
        while (lines_sent < 1600) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            send_frame(k < 85 ? $urandom_range(1, 8) : $urandom_range(9, 20));
        end
        no_gaps = 0;
        s_tvalid <= 0;
        s_tlast <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (board.mean_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d lines in %0d frames, %0d mean results checked,",
                 lines_sent, frames_sent, board.results_seen);
        $display("including parallel-only, lone-line and overflowing frames.");
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Timed out with %0d results outstanding", board.mean_q.size());
        $display("Mismatches found");
        $finish;
    end
endmodule
